// ----- rtl/pal_pkg.sv -----
// ---------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list: operation
// codes, result status codes, sequencer states and fixed field widths.
// ---------------------------------------------------------------------------
package pal_pkg;

   // fixed field widths of the stream payloads
   localparam int FUNC_W     = 3;
   localparam int POS_W      = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int FIDX_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 40;   // position + value, padded to bytes
   localparam int RSP_DATA_W = 48;   // value_out + found_index + count_out, padded

   // operation selector carried in req_tuser
   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_GET    = 3'd2,
      OP_FIRST  = 3'd3,
      OP_LAST   = 3'd4,
      OP_FIND   = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   // result status carried in rsp_tuser
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_CAPT,
      S_INS_RD,
      S_INS_WR,
      S_RM_RD,
      S_RM_WR,
      S_FIND_RD,
      S_FIND_CMP,
      S_DONE
   } state_type;

endpackage

// ----- rtl/positional_array_list.sv -----
// ---------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to DEPTH handles held in a slot memory with separate
// read and write ports, with insert/remove at a position, get, first, last, find and clear.
// ---------------------------------------------------------------------------
// Each request transfer carries an operation in req_tuser and a position and
// handle in req_tdata; each produces exactly one response transfer. The list
// lives in a memory with one write and one registered read port, and a small
// sequencer walks it one entry at a time, reading a slot and then writing or
// comparing it, so the cost of an operation is set by how many entries it
// must move or visit: insert moves the entries from the position to the end,
// remove those after the position, find visits entries up to the match (all
// of them on a miss), and get, first, last, clear and rejected operations
// move none. A new request is taken once the previous one has reached the
// response register, even while that response still waits for rsp_tready.
// ---------------------------------------------------------------------------
module positional_array_list #(
   parameter int DEPTH        = 64,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pal_pkg::REQ_DATA_W-1:0]      req_tdata,  // position[6:0], value[38:7], pad
   input  logic [pal_pkg::FUNC_W-1:0]          req_tuser,  // func[2:0]
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pal_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // value_out[31:0], found_index[37:32],
                                                           // count_out[44:38], pad
   output logic [pal_pkg::STATUS_W-1:0]        rsp_tuser   // status[1:0]
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;
   localparam int EXT_W  = (HANDLE_WIDTH > pal_pkg::VALUE_W) ? HANDLE_WIDTH : pal_pkg::VALUE_W;

   // slot memory
   logic [HANDLE_WIDTH-1:0] mem [DEPTH];
   logic [HANDLE_WIDTH-1:0] rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wa;
   logic [HANDLE_WIDTH-1:0] mem_wd;
   logic [ADDR_W-1:0]       mem_ra;

   // sequencer and working registers
   pal_pkg::state_type            state_ff, state_in;
   pal_pkg::op_type               func_ff, func_in;
   logic [pal_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [HANDLE_WIDTH-1:0]       val_ff, val_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [pal_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [HANDLE_WIDTH-1:0]       vout_ff, vout_in;
   logic [ADDR_W-1:0]             fidx_ff, fidx_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pal_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pal_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [pal_pkg::FIDX_W-1:0]    rsp_fidx_ff, rsp_fidx_in;
   logic [pal_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // request field split
   logic [pal_pkg::POS_W-1:0]     req_pos;
   logic [EXT_W-1:0]              req_val_ext;
   logic [CMP_W-1:0]              req_pos_cmp;
   logic [CMP_W-1:0]              count_cmp;
   logic [CNT_W-1:0]              idx_nx;
   logic [CNT_W-1:0]              idx_pv;
   logic [EXT_W-1:0]              vout_ext;
   logic                          req_fire;

   assign req_pos     = req_tdata[pal_pkg::POS_W-1:0];
   assign req_val_ext = EXT_W'(req_tdata[pal_pkg::POS_W +: pal_pkg::VALUE_W]);
   assign req_pos_cmp = CMP_W'(req_pos);
   assign count_cmp   = CMP_W'(count_ff);
   assign idx_nx      = idx_ff + CNT_W'(1);
   assign idx_pv      = idx_ff - CNT_W'(1);
   assign vout_ext    = EXT_W'(vout_ff);

   assign req_tready  = (state_ff == pal_pkg::S_IDLE);
   assign req_fire    = req_tvalid && req_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tuser   = rsp_status_ff;
   assign rsp_tdata   = {(pal_pkg::RSP_DATA_W - pal_pkg::VALUE_W - pal_pkg::FIDX_W
                          - pal_pkg::COUNT_W)'(0),
                         rsp_count_ff, rsp_fidx_ff, rsp_value_ff};

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pal_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      fidx_ff       <= fidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // sequencer: next state, memory control, results
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      vout_in       = vout_ff;
      fidx_in       = fidx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff[ADDR_W-1:0];
      mem_wd        = rd_data_ff;
      mem_ra        = idx_ff[ADDR_W-1:0];

      // response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pal_pkg::S_IDLE: begin
            if (req_fire) begin
               func_in   = pal_pkg::op_type'(req_tuser);
               pos_in    = req_pos;
               val_in    = req_val_ext[HANDLE_WIDTH-1:0];
               status_in = pal_pkg::ST_OK;
               vout_in   = '0;
               fidx_in   = '0;
               state_in  = pal_pkg::S_DONE;
               case (pal_pkg::op_type'(req_tuser))
                  pal_pkg::OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = pal_pkg::ST_FULL;
                     end else if (req_pos_cmp > count_cmp) begin
                        status_in = pal_pkg::ST_MISS;
                     end else begin
                        idx_in   = count_ff;
                        state_in = pal_pkg::S_INS_RD;
                     end
                  end
                  pal_pkg::OP_REMOVE, pal_pkg::OP_GET: begin
                     if (req_pos_cmp >= count_cmp) begin
                        status_in = pal_pkg::ST_MISS;
                     end else begin
                        idx_in   = CNT_W'(req_pos);
                        state_in = pal_pkg::S_FETCH;
                     end
                  end
                  pal_pkg::OP_FIRST: begin
                     if (count_ff == '0) begin
                        status_in = pal_pkg::ST_MISS;
                     end else begin
                        idx_in   = '0;
                        state_in = pal_pkg::S_FETCH;
                     end
                  end
                  pal_pkg::OP_LAST: begin
                     if (count_ff == '0) begin
                        status_in = pal_pkg::ST_MISS;
                     end else begin
                        idx_in   = count_ff - CNT_W'(1);
                        state_in = pal_pkg::S_FETCH;
                     end
                  end
                  pal_pkg::OP_FIND: begin
                     status_in = pal_pkg::ST_MISS;
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        state_in = pal_pkg::S_FIND_RD;
                     end
                  end
                  pal_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = pal_pkg::ST_MISS;
                  end
               endcase
            end
         end

         // read the addressed slot
         pal_pkg::S_FETCH: begin
            mem_ra   = idx_ff[ADDR_W-1:0];
            state_in = pal_pkg::S_CAPT;
         end

         // slot data is back: keep it, then close up the gap on remove
         pal_pkg::S_CAPT: begin
            vout_in = rd_data_ff;
            if (func_ff == pal_pkg::OP_REMOVE) begin
               state_in = pal_pkg::S_RM_RD;
            end else begin
               state_in = pal_pkg::S_DONE;
            end
         end

         // insert: walk down from the end, moving each entry up by one
         pal_pkg::S_INS_RD: begin
            if (CMP_W'(idx_ff) == CMP_W'(pos_ff)) begin
               mem_we   = 1'b1;
               mem_wa   = idx_ff[ADDR_W-1:0];
               mem_wd   = val_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = pal_pkg::S_DONE;
            end else begin
               mem_ra   = idx_pv[ADDR_W-1:0];
               state_in = pal_pkg::S_INS_WR;
            end
         end

         pal_pkg::S_INS_WR: begin
            mem_we   = 1'b1;
            mem_wa   = idx_ff[ADDR_W-1:0];
            mem_wd   = rd_data_ff;
            idx_in   = idx_pv;
            state_in = pal_pkg::S_INS_RD;
         end

         // remove: walk up from the position, moving each entry down by one
         pal_pkg::S_RM_RD: begin
            if (idx_nx >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = pal_pkg::S_DONE;
            end else begin
               mem_ra   = idx_nx[ADDR_W-1:0];
               state_in = pal_pkg::S_RM_WR;
            end
         end

         pal_pkg::S_RM_WR: begin
            mem_we   = 1'b1;
            mem_wa   = idx_ff[ADDR_W-1:0];
            mem_wd   = rd_data_ff;
            idx_in   = idx_nx;
            state_in = pal_pkg::S_RM_RD;
         end

         // find: compare one slot per pass, stop at the first match
         pal_pkg::S_FIND_RD: begin
            mem_ra   = idx_ff[ADDR_W-1:0];
            state_in = pal_pkg::S_FIND_CMP;
         end

         pal_pkg::S_FIND_CMP: begin
            if (rd_data_ff == val_ff) begin
               status_in = pal_pkg::ST_OK;
               fidx_in   = idx_ff[ADDR_W-1:0];
               state_in  = pal_pkg::S_DONE;
            end else if (idx_nx >= count_ff) begin
               state_in  = pal_pkg::S_DONE;
            end else begin
               idx_in    = idx_nx;
               state_in  = pal_pkg::S_FIND_RD;
            end
         end

         // hand the result to the response register once it is free
         pal_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = vout_ext[pal_pkg::VALUE_W-1:0];
               rsp_fidx_in   = pal_pkg::FIDX_W'(fidx_ff);
               rsp_count_in  = pal_pkg::COUNT_W'(count_ff);
               state_in      = pal_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pal_pkg::S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // the element count never passes the list capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count above capacity");

   // slots are written only while an insert or remove is moving entries
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == pal_pkg::S_INS_RD || state_ff == pal_pkg::S_INS_WR ||
                  state_ff == pal_pkg::S_RM_WR))
      else $error("slot write outside insert or remove");

   // a response is loaded only on leaving the done state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pal_pkg::S_DONE)
      else $error("response raised outside done state");

   // the count moves by at most one per cycle, except for clear
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && count_ff != '0) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count jumped");
`endif

endmodule
